### design/smeu_pkg.sv
// ----------------------------------------------------------------------------
// smeu_pkg
// Opcodes, status codes and state types of the stack machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package smeu_pkg;

    localparam logic [5:0] OP_PUSH     = 6'd0;
    localparam logic [5:0] OP_POP      = 6'd1;
    localparam logic [5:0] OP_STORE    = 6'd2;
    localparam logic [5:0] OP_LOAD     = 6'd3;
    localparam logic [5:0] OP_DUP      = 6'd4;
    localparam logic [5:0] OP_SWAP     = 6'd5;
    localparam logic [5:0] OP_ADD      = 6'd6;
    localparam logic [5:0] OP_SUB      = 6'd7;
    localparam logic [5:0] OP_MUL      = 6'd8;
    localparam logic [5:0] OP_DIV      = 6'd9;
    localparam logic [5:0] OP_MOD      = 6'd10;
    localparam logic [5:0] OP_INC      = 6'd11;
    localparam logic [5:0] OP_DEC      = 6'd12;
    localparam logic [5:0] OP_AND      = 6'd13;
    localparam logic [5:0] OP_OR       = 6'd14;
    localparam logic [5:0] OP_XOR      = 6'd15;
    localparam logic [5:0] OP_NOT      = 6'd16;
    localparam logic [5:0] OP_SHL      = 6'd17;
    localparam logic [5:0] OP_SHR      = 6'd18;
    localparam logic [5:0] OP_EQ       = 6'd19;
    localparam logic [5:0] OP_NE       = 6'd20;
    localparam logic [5:0] OP_GT       = 6'd21;
    localparam logic [5:0] OP_NGT      = 6'd22;
    localparam logic [5:0] OP_LT       = 6'd23;
    localparam logic [5:0] OP_NLT      = 6'd24;
    localparam logic [5:0] OP_GE       = 6'd25;
    localparam logic [5:0] OP_NGE      = 6'd26;
    localparam logic [5:0] OP_LE       = 6'd27;
    localparam logic [5:0] OP_NLE      = 6'd28;
    localparam logic [5:0] OP_JMPIF    = 6'd32;
    localparam logic [5:0] OP_JMPIFNOT = 6'd33;
    localparam logic [5:0] OP_SYS      = 6'd34;

    localparam logic [1:0] AUX_RET   = 2'd0;
    localparam logic [1:0] AUX_HALT  = 2'd1;
    localparam logic [1:0] AUX_PRINT = 2'd2;

    localparam logic [3:0] ST_OK         = 4'd0;
    localparam logic [3:0] ST_STK_FULL   = 4'd1;
    localparam logic [3:0] ST_STK_EMPTY  = 4'd2;
    localparam logic [3:0] ST_FEW_OPS    = 4'd3;
    localparam logic [3:0] ST_SLOT_FULL  = 4'd4;
    localparam logic [3:0] ST_SLOT_EMPTY = 4'd5;
    localparam logic [3:0] ST_UNIMPL     = 4'd6;
    localparam logic [3:0] ST_DIV_ZERO   = 4'd7;
    localparam logic [3:0] ST_BAD_SLOT   = 4'd8;

    typedef enum logic [1:0] {
        MD_MUL,
        MD_DIV,
        MD_MOD
    } md_kind_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ARITH,
        S_SWAP
    } state_t;

endpackage

`default_nettype wire

### design/smeu_stack_mem.sv
// ----------------------------------------------------------------------------
// smeu_stack_mem
// Operand stack storage: one write port, two registered read ports.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_stack_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          re,
    input  logic [AW-1:0] ra_addr,
    input  logic [AW-1:0] rb_addr,
    output logic [63:0]   ra_data,
    output logic [63:0]   rb_data,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [63:0]   wd
);
    logic [63:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            ra_data <= mem[ra_addr];
            rb_data <= mem[rb_addr];
        end
    end

endmodule

`default_nettype wire

### design/smeu_slot_mem.sv
// ----------------------------------------------------------------------------
// smeu_slot_mem
// Slot file storage with per-entry valid bits; unwritten entries read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_slot_mem #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          re,
    input  logic [AW-1:0] ra,
    output logic [63:0]   rd,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [63:0]   wd
);
    logic [63:0]    mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [63:0]    rd_reg;
    logic           rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rd_reg <= mem[ra];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[wa] <= 1'b1;
            end
            if (re)
            begin
                rvld_reg <= vld_reg[ra];
            end
        end
    end

    assign rd = rvld_reg ? rd_reg : 64'd0;

endmodule

`default_nettype wire

### design/smeu_muldiv.sv
// ----------------------------------------------------------------------------
// smeu_muldiv
// Iterative multiply (three 32x32 partial products) and signed divide /
// remainder (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_muldiv (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  smeu_pkg::md_kind_t kind,
    input  logic [63:0]        a,
    input  logic [63:0]        b,
    output logic               done,
    output logic [63:0]        result
);
    import smeu_pkg::*;

    md_kind_t    kind_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [6:0]  step_reg;
    logic [63:0] acc_reg;
    logic [63:0] rem_reg;
    logic [63:0] x_reg;
    logic [63:0] y_reg;
    logic        neg_q_reg;
    logic        neg_r_reg;

    logic [31:0] mx;
    logic [31:0] my;
    logic [63:0] prod;
    logic [64:0] tmp;
    logic [64:0] diff;
    logic        last;

    always_comb
    begin
        case (step_reg[1:0])
            2'd0:    begin mx = x_reg[31:0];  my = y_reg[31:0];  end
            2'd1:    begin mx = x_reg[31:0];  my = y_reg[63:32]; end
            default: begin mx = x_reg[63:32]; my = y_reg[31:0];  end
        endcase
        prod = 64'(mx) * 64'(my);
        tmp  = {rem_reg, acc_reg[63]};
        diff = tmp - {1'b0, y_reg};
        last = (kind_reg == MD_MUL) ? (step_reg == 7'd2) : (step_reg == 7'd63);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else if (busy_reg)
        begin
            step_reg <= step_reg + 7'd1;
            if (last)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            kind_reg  <= kind;
            neg_q_reg <= a[63] ^ b[63];
            neg_r_reg <= a[63];
            rem_reg   <= '0;
            if (kind == MD_MUL)
            begin
                x_reg   <= a;
                y_reg   <= b;
            end
            else
            begin
                acc_reg <= a[63] ? (~a + 64'd1) : a;
                y_reg   <= b[63] ? (~b + 64'd1) : b;
            end
        end
        else if (busy_reg)
        begin
            if (kind_reg == MD_MUL)
            begin
                if (step_reg == 7'd0)
                begin
                    acc_reg <= prod;
                end
                else
                begin
                    acc_reg <= acc_reg + {prod[31:0], 32'd0};
                end
            end
            else
            begin
                acc_reg <= {acc_reg[62:0], ~diff[64]};
                rem_reg <= diff[64] ? tmp[63:0] : diff[63:0];
            end
        end
    end

    always_comb
    begin
        case (kind_reg)
            MD_DIV:  result = neg_q_reg ? (~acc_reg + 64'd1) : acc_reg;
            MD_MOD:  result = neg_r_reg ? (~rem_reg + 64'd1) : rem_reg;
            default: result = acc_reg;
        endcase
    end

    assign done = done_reg;

endmodule

`default_nettype wire

### design/stack_machine_execute_unit.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit
// Integer stack machine: one instruction word in, one status word out.
// ----------------------------------------------------------------------------
// Input words on s_*: tdata = {operand, cmd}, tuser = aux_op. One instruction
// is taken at a time. Acceptance issues the stack and slot memory reads; S_EXEC
// then executes and writes back once the output register is free. Swap adds
// S_SWAP (two stack writes on the single write port); valid mul/div/mod wait in
// S_ARITH on smeu_muldiv (three 32x32 partial products; one quotient bit per
// cycle). The result word sits in an output register on m_*; a new
// instruction is taken while it waits, but the following commit holds until
// m_tready frees the register. cfg_we writes stack_limit (reset 64).
// Reset empties the stack, clears all slots to zero (valid bits), sets pc to
// zero and running to one; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_unit #(
    parameter int STACK_DEPTH = 64,
    parameter int PC_WIDTH    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [6:0]   cfg_wdata,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [71:0]  s_tdata,   // cmd[5:0], operand[69:6], zero pad
    input  logic [1:0]   s_tuser,   // aux_op[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [159:0] m_tdata,   // status[3:0], pc_value[19:4], print_value[83:20],
                                    // top_value[147:84], stack_depth[154:148],
                                    // running[155], zero pad
    output logic [0:0]   m_tuser    // print_valid
);
    import smeu_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int LW = (CW > 7) ? CW : 7;
    localparam logic [LW-1:0] DEPTH_L = LW'(STACK_DEPTH);

    state_t         state_reg, state_next;
    logic [6:0]     limit_reg;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  scnt_reg, scnt_next;
    logic [PC_WIDTH-1:0] pc_reg, pc_next;
    logic           run_reg, run_next;
    logic [5:0]     cmd_reg;
    logic [63:0]    opnd_reg;
    logic [1:0]     aux_reg;
    logic           out_valid_reg;
    logic [159:0]   out_data_reg;
    logic           out_pv_reg;

    logic           accept;
    logic           out_free;
    logic           commit;
    logic [LW-1:0]  lim;
    logic [LW-1:0]  n_l;
    logic [LW-1:0]  sc_l;
    logic [CW-1:0]  n_m1;
    logic [CW-1:0]  n_m2;
    logic [CW-1:0]  in_m1;
    logic [CW-1:0]  in_m2;
    logic [63:0]    a;
    logic [63:0]    b;
    logic [63:0]    slotv;
    logic           bad_slot;
    logic           full;
    logic           has1;
    logic           has2;
    logic [63:0]    alu;
    logic [63:0]    res;
    logic           md_need;
    md_kind_t       md_kind;
    logic           md_done;
    logic [63:0]    md_res;
    logic           cmp;

    logic [3:0]     st;
    logic           adv;
    logic           stk_we;
    logic [AW-1:0]  stk_wa;
    logic [63:0]    stk_wd;
    logic           slot_we;
    logic [63:0]    top;
    logic           pv;
    logic [63:0]    pval;
    logic [63:0]    x_top_keep;
    logic [63:0]    x_top_pop;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == S_IDLE);
    assign out_free = !out_valid_reg || m_tready;

    assign lim   = (LW'(limit_reg) > DEPTH_L) ? DEPTH_L : LW'(limit_reg);
    assign n_l   = LW'(cnt_reg);
    assign sc_l  = LW'(scnt_reg);
    assign n_m1  = cnt_reg - CW'(1);
    assign n_m2  = cnt_reg - CW'(2);
    assign in_m1 = cnt_reg - CW'(1);
    assign in_m2 = cnt_reg - CW'(2);
    assign full  = n_l >= lim;
    assign has1  = cnt_reg != '0;
    assign has2  = cnt_reg > CW'(1);
    assign bad_slot = opnd_reg[63] || (opnd_reg[62:0] >= 63'(STACK_DEPTH));

    smeu_stack_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_stack (
        .clk     (clk),
        .re      (accept),
        .ra_addr (in_m2[AW-1:0]),
        .rb_addr (in_m1[AW-1:0]),
        .ra_data (a),
        .rb_data (b),
        .we      (stk_we),
        .wa      (stk_wa),
        .wd      (stk_wd)
    );

    smeu_slot_mem #(.DEPTH(STACK_DEPTH), .AW(AW)) u_slot (
        .clk   (clk),
        .rst_n (rst_n),
        .re    (accept),
        .ra    (s_tdata[6 +: AW]),
        .rd    (slotv),
        .we    (slot_we),
        .wa    (opnd_reg[AW-1:0]),
        .wd    (b)
    );

    smeu_muldiv u_md (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (state_reg == S_EXEC && md_need),
        .kind   (md_kind),
        .a      (a),
        .b      (b),
        .done   (md_done),
        .result (md_res)
    );

    always_comb
    begin
        case (cmd_reg)
            OP_EQ:   cmp = $signed(a[31:0]) == $signed(b[31:0]);
            OP_NE:   cmp = $signed(a[31:0]) != $signed(b[31:0]);
            OP_GT:   cmp = $signed(a[31:0]) >  $signed(b[31:0]);
            OP_NGT:  cmp = !($signed(a[31:0]) >  $signed(b[31:0]));
            OP_LT:   cmp = $signed(a[31:0]) <  $signed(b[31:0]);
            OP_NLT:  cmp = !($signed(a[31:0]) <  $signed(b[31:0]));
            OP_GE:   cmp = $signed(a[31:0]) >= $signed(b[31:0]);
            OP_NGE:  cmp = !($signed(a[31:0]) >= $signed(b[31:0]));
            OP_LE:   cmp = $signed(a[31:0]) <= $signed(b[31:0]);
            default: cmp = !($signed(a[31:0]) <= $signed(b[31:0]));
        endcase

        case (cmd_reg)
            OP_ADD:  alu = a + b;
            OP_SUB:  alu = a - b;
            OP_AND:  alu = a & b;
            OP_OR:   alu = a | b;
            OP_XOR:  alu = a ^ b;
            OP_SHL:  alu = (|b[63:6]) ? 64'd0 : (a << b[5:0]);
            OP_SHR:  alu = (|b[63:6]) ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
            default: alu = {63'd0, cmp};
        endcase

        case (cmd_reg)
            OP_DIV:  md_kind = MD_DIV;
            OP_MOD:  md_kind = MD_MOD;
            default: md_kind = MD_MUL;
        endcase
        md_need = has2 && ((cmd_reg == OP_MUL) ||
                  ((cmd_reg == OP_DIV || cmd_reg == OP_MOD) && (b != 64'd0)));
        res = (state_reg == S_ARITH) ? md_res : alu;
    end

    // execute and write back
    always_comb
    begin
        x_top_keep = has1 ? b : 64'd0;
        x_top_pop  = has2 ? a : 64'd0;
        st        = ST_OK;
        adv       = 1'b1;
        cnt_next  = cnt_reg;
        scnt_next = scnt_reg;
        run_next  = run_reg;
        stk_we    = 1'b0;
        stk_wa    = cnt_reg[AW-1:0];
        stk_wd    = opnd_reg;
        slot_we   = 1'b0;
        top       = x_top_keep;
        pv        = 1'b0;
        pval      = 64'd0;
        case (cmd_reg)
            OP_PUSH:
            begin
                if (full) st = ST_STK_FULL;
                else begin stk_we = 1'b1; cnt_next = cnt_reg + CW'(1); top = opnd_reg; end
            end
            OP_POP:
            begin
                if (!has1) st = ST_STK_EMPTY;
                else begin cnt_next = n_m1; top = x_top_pop; end
            end
            OP_STORE:
            begin
                if (sc_l >= lim) st = ST_SLOT_FULL;
                else if (!has1) st = ST_STK_EMPTY;
                else if (bad_slot) st = ST_BAD_SLOT;
                else
                begin
                    slot_we   = 1'b1;
                    scnt_next = scnt_reg + CW'(1);
                    cnt_next  = n_m1;
                    top       = x_top_pop;
                end
            end
            OP_LOAD:
            begin
                if (scnt_reg == '0) st = ST_SLOT_EMPTY;
                else if (full) st = ST_STK_FULL;
                else if (bad_slot) st = ST_BAD_SLOT;
                else
                begin
                    stk_we = 1'b1; stk_wd = slotv;
                    cnt_next = cnt_reg + CW'(1); top = slotv;
                end
            end
            OP_DUP:
            begin
                if (full) st = ST_STK_FULL;
                else if (!has1) st = ST_STK_EMPTY;
                else begin stk_we = 1'b1; stk_wd = b; cnt_next = cnt_reg + CW'(1); end
            end
            OP_SWAP:
            begin
                if (!has2) st = ST_FEW_OPS;
                else begin stk_we = 1'b1; stk_wa = n_m1[AW-1:0]; stk_wd = a; top = a; end
            end
            OP_INC, OP_DEC, OP_NOT:
            begin
                if (!has1) st = ST_STK_EMPTY;
                else
                begin
                    stk_we = 1'b1;
                    stk_wa = n_m1[AW-1:0];
                    case (cmd_reg)
                        OP_INC:  stk_wd = b + 64'd1;
                        OP_DEC:  stk_wd = b - 64'd1;
                        default: stk_wd = ~b;
                    endcase
                    top = stk_wd;
                end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_AND, OP_OR, OP_XOR,
            OP_SHL, OP_SHR, OP_EQ, OP_NE, OP_GT, OP_NGT, OP_LT, OP_NLT,
            OP_GE, OP_NGE, OP_LE, OP_NLE:
            begin
                if (!has2) st = ST_FEW_OPS;
                else if ((cmd_reg == OP_DIV || cmd_reg == OP_MOD) && b == 64'd0)
                    st = ST_DIV_ZERO;
                else
                begin
                    stk_we = 1'b1; stk_wa = n_m2[AW-1:0]; stk_wd = res;
                    cnt_next = n_m1; top = res;
                end
            end
            OP_JMPIF, OP_JMPIFNOT:
            begin
                if (!has1) st = ST_STK_EMPTY;
                else if ((b != 64'd0) == (cmd_reg == OP_JMPIF)) adv = 1'b0;
            end
            OP_SYS:
            begin
                if (aux_reg == AUX_RET || aux_reg == AUX_HALT)
                begin
                    if (full) st = ST_STK_FULL;
                    else
                    begin
                        stk_we = 1'b1; cnt_next = cnt_reg + CW'(1); top = opnd_reg;
                        if (aux_reg == AUX_HALT) run_next = 1'b0;
                    end
                end
                else if (aux_reg == AUX_PRINT)
                begin
                    if (!has1) st = ST_STK_EMPTY;
                    else begin cnt_next = n_m1; top = x_top_pop; pv = 1'b1; pval = b; end
                end
                else st = ST_UNIMPL;
            end
            default: st = ST_UNIMPL;
        endcase
        if (st != ST_OK) pc_next = pc_reg;
        else if (!adv) pc_next = opnd_reg[PC_WIDTH-1:0];
        else pc_next = pc_reg + PC_WIDTH'(1);

        if (state_reg == S_SWAP)
        begin
            stk_we = 1'b1;
            stk_wa = n_m2[AW-1:0];
            stk_wd = b;
        end
        else if (!commit)
        begin
            stk_we  = 1'b0;
            slot_we = 1'b0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        commit     = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept) state_next = S_EXEC;
            end
            S_EXEC:
            begin
                if (md_need) state_next = S_ARITH;
                else if (out_free)
                begin
                    commit = 1'b1;
                    state_next = (cmd_reg == OP_SWAP && has2) ? S_SWAP : S_IDLE;
                end
            end
            S_ARITH:
            begin
                if (md_done && out_free)
                begin
                    commit = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_SWAP:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            limit_reg     <= 7'd64;
            cnt_reg       <= '0;
            scnt_reg      <= '0;
            pc_reg        <= '0;
            run_reg       <= 1'b1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                limit_reg <= cfg_wdata;
            end
            if (commit)
            begin
                cnt_reg       <= cnt_next;
                scnt_reg      <= scnt_next;
                pc_reg        <= pc_next;
                run_reg       <= run_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_tdata[5:0];
            opnd_reg <= s_tdata[69:6];
            aux_reg  <= s_tuser;
        end
        if (commit)
        begin
            out_pv_reg   <= pv;
            out_data_reg <= {4'd0, run_next, 7'(cnt_next), top, pval, 16'(pc_next), st};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_pv_reg;

endmodule

`default_nettype wire

### design/smeu_checker.sv
// ----------------------------------------------------------------------------
// smeu_checker
// Port-level checks for the stack machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

module smeu_checker (
    input wire         clk,
    input wire         rst_n,
    input wire         s_tvalid,
    input wire         s_tready,
    input wire         m_tvalid,
    input wire         m_tready,
    input wire [159:0] m_tdata,
    input wire [0:0]   m_tuser
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second word taken while busy");

    a_print_ok: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata[3:0] == 4'd0)
        else $error("print flagged on failed instruction");

    a_empty_top: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[154:148] == 7'd0 |-> m_tdata[147:84] == 64'd0)
        else $error("nonzero top on empty stack");

endmodule

bind stack_machine_execute_unit smeu_checker u_smeu_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### test/stack_machine_execute_unit_tb.sv
// ----------------------------------------------------------------------------
// stack_machine_execute_unit_tb
// Drives instruction words into the stack machine execute unit and checks
// every status word against a cycle-free model of the unit's state. A short
// directed run covers error codes and corner values. Random runs follow, with
// several stack_limit settings and changing source/sink idle patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module stack_machine_execute_unit_tb;
    import smeu_pkg::*;

    localparam int DEPTH = 64;
    localparam int IDLE_LIMIT = 20000;
    localparam int DRAIN_CYCLES = 80;
    localparam logic [5:0] OP_RSV_A = 6'd29;
    localparam logic [5:0] OP_RSV_B = 6'd30;
    localparam logic [5:0] OP_JMP = 6'd31;
    localparam logic [5:0] OP_TOP = 6'd63;
    localparam logic [1:0] AUX_BAD = 2'd3;
    localparam logic [63:0] V_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] V_MAX = 64'h7fff_ffff_ffff_ffff;

    typedef struct packed {
        logic [3:0]  status;
        logic [15:0] pc;
        logic        pv;
        logic [63:0] pval;
        logic [63:0] top;
        logic [6:0]  depth;
        logic        run;
    } status_word_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         cfg_we;
    logic [6:0]   cfg_wdata;
    logic         s_tvalid;
    logic         s_tready;
    logic [71:0]  s_tdata;   // cmd[5:0], operand[69:6], zero pad
    logic [1:0]   s_tuser;   // aux_op
    logic         m_tvalid;
    logic         m_tready;
    logic [159:0] m_tdata;   // status, pc_value, print_value, top_value, stack_depth, running
    logic [0:0]   m_tuser;   // print_valid

    // Unit state as the model tracks it
    logic [63:0]  stk_mem [DEPTH];
    logic [63:0]  slot_mem [DEPTH];
    int           stk_cnt;
    int           slot_cnt;
    logic [15:0]  pc_reg;
    logic         run_reg;
    int           limit_reg;

    status_word_t expected_q[$];
    int           errors;
    int           words_sent;
    int           words_checked;
    int           prints_seen;
    int           send_idle_pct;
    int           sink_stall_pct;
    int           idle_cycles;

    stack_machine_execute_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    function automatic logic [63:0] neg64(input logic [63:0] v);
        return ~v + 64'd1;
    endfunction

    task automatic execute_instr(input logic [5:0] c, input logic [63:0] v,
                                 input logic [1:0] ax);
        status_word_t w;
        int           cap;
        int           n;
        logic         adv;
        logic [3:0]   st;
        logic [63:0]  a;
        logic [63:0]  b;
        logic [63:0]  res;
        logic [63:0]  ma;
        logic [63:0]  mb;
        logic signed [31:0] x;
        logic signed [31:0] y;
        cap = (limit_reg < DEPTH) ? limit_reg : DEPTH;
        n = stk_cnt;
        adv = 1'b1;
        st = ST_OK;
        w = '0;
        if (c == OP_PUSH) begin
            if (n >= cap) st = ST_STK_FULL;
            else begin stk_mem[n] = v; stk_cnt++; end
        end else if (c == OP_POP) begin
            if (n < 1) st = ST_STK_EMPTY;
            else stk_cnt--;
        end else if (c == OP_STORE) begin
            if (slot_cnt >= cap) st = ST_SLOT_FULL;
            else if (n < 1) st = ST_STK_EMPTY;
            else if (v >= DEPTH) st = ST_BAD_SLOT;
            else begin
                stk_cnt--;
                slot_mem[v[5:0]] = stk_mem[stk_cnt];
                slot_cnt++;
            end
        end else if (c == OP_LOAD) begin
            if (slot_cnt < 1) st = ST_SLOT_EMPTY;
            else if (n >= cap) st = ST_STK_FULL;
            else if (v >= DEPTH) st = ST_BAD_SLOT;
            else begin stk_mem[n] = slot_mem[v[5:0]]; stk_cnt++; end
        end else if (c == OP_DUP) begin
            if (n >= cap) st = ST_STK_FULL;
            else if (n < 1) st = ST_STK_EMPTY;
            else begin stk_mem[n] = stk_mem[n-1]; stk_cnt++; end
        end else if (c == OP_SWAP) begin
            if (n < 2) st = ST_FEW_OPS;
            else begin
                a = stk_mem[n-2];
                stk_mem[n-2] = stk_mem[n-1];
                stk_mem[n-1] = a;
            end
        end else if (c == OP_INC || c == OP_DEC || c == OP_NOT) begin
            if (n < 1) st = ST_STK_EMPTY;
            else if (c == OP_INC) stk_mem[n-1] = stk_mem[n-1] + 64'd1;
            else if (c == OP_DEC) stk_mem[n-1] = stk_mem[n-1] - 64'd1;
            else stk_mem[n-1] = ~stk_mem[n-1];
        end else if (c >= OP_ADD && c <= OP_NLE) begin
            if (n < 2) st = ST_FEW_OPS;
            else begin
                a = stk_mem[n-2];
                b = stk_mem[n-1];
                x = a[31:0];
                y = b[31:0];
                ma = a[63] ? neg64(a) : a;
                mb = b[63] ? neg64(b) : b;
                res = '0;
                if ((c == OP_DIV || c == OP_MOD) && b == 64'd0) st = ST_DIV_ZERO;
                else begin
                    case (c)
                        OP_ADD: res = a + b;
                        OP_SUB: res = a - b;
                        OP_MUL: res = a * b;
                        OP_DIV: res = (a[63] ^ b[63]) ? neg64(ma / mb) : ma / mb;
                        OP_MOD: res = a[63] ? neg64(ma % mb) : ma % mb;
                        OP_AND: res = a & b;
                        OP_OR:  res = a | b;
                        OP_XOR: res = a ^ b;
                        OP_SHL: res = (b >= 64) ? 64'd0 : a << b[5:0];
                        OP_SHR: res = (b >= 64) ? {64{a[63]}} : 64'($signed(a) >>> b[5:0]);
                        OP_EQ:  res = 64'(x == y);
                        OP_NE:  res = 64'(x != y);
                        OP_GT:  res = 64'(x > y);
                        OP_NGT: res = 64'(!(x > y));
                        OP_LT:  res = 64'(x < y);
                        OP_NLT: res = 64'(!(x < y));
                        OP_GE:  res = 64'(x >= y);
                        OP_NGE: res = 64'(!(x >= y));
                        OP_LE:  res = 64'(x <= y);
                        default: res = 64'(!(x <= y));
                    endcase
                    stk_mem[n-2] = res;
                    stk_cnt--;
                end
            end
        end else if (c == OP_JMPIF || c == OP_JMPIFNOT) begin
            if (n < 1) st = ST_STK_EMPTY;
            else if ((stk_mem[n-1] != 64'd0) == (c == OP_JMPIF)) begin
                pc_reg = v[15:0];
                adv = 1'b0;
            end
        end else if (c == OP_SYS && (ax == AUX_RET || ax == AUX_HALT)) begin
            if (n >= cap) st = ST_STK_FULL;
            else begin
                stk_mem[n] = v;
                stk_cnt++;
                if (ax == AUX_HALT) run_reg = 1'b0;
            end
        end else if (c == OP_SYS && ax == AUX_PRINT) begin
            if (n < 1) st = ST_STK_EMPTY;
            else begin
                stk_cnt--;
                w.pv = 1'b1;
                w.pval = stk_mem[stk_cnt];
            end
        end else begin
            st = ST_UNIMPL;
        end
        if (st == ST_OK && adv) pc_reg = pc_reg + 16'd1;
        w.status = st;
        w.pc = pc_reg;
        w.top = (stk_cnt > 0) ? stk_mem[stk_cnt-1] : 64'd0;
        w.depth = 7'(stk_cnt);
        w.run = run_reg;
        expected_q.push_back(w);
    endtask

    task automatic send_instr(input logic [5:0] c, input logic [63:0] v,
                              input logic [1:0] ax);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, v, c};
        s_tuser <= ax;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        execute_instr(c, v, ax);
        words_sent++;
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_limit(input logic [6:0] lim);
        drain();
        cfg_we <= 1'b1;
        cfg_wdata <= lim;
        @(posedge clk);
        cfg_we <= 1'b0;
        limit_reg = lim;
    endtask

    function automatic logic [63:0] pick_value();
        case ($urandom_range(7))
            0: return V_MIN;
            1: return V_MAX;
            2: return 64'(signed'(-$urandom_range(70)));
            3: return 64'($urandom_range(70));
            4: return '1;
            5: return '0;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic test_directed();
        send_instr(OP_POP, 0, AUX_RET);
        send_instr(OP_SWAP, 0, AUX_RET);
        send_instr(OP_LOAD, 0, AUX_RET);
        send_instr(OP_SYS, 0, AUX_PRINT);
        send_instr(OP_JMPIF, 5, AUX_RET);
        send_instr(OP_PUSH, V_MIN, AUX_RET);
        send_instr(OP_PUSH, '1, AUX_RET);
        send_instr(OP_DIV, 0, AUX_RET);
        send_instr(OP_PUSH, 0, AUX_RET);
        send_instr(OP_MOD, 0, AUX_RET);
        send_instr(OP_POP, 0, AUX_RET);
        send_instr(OP_PUSH, 64, AUX_RET);
        send_instr(OP_SHR, 0, AUX_RET);
        send_instr(OP_PUSH, 3, AUX_RET);
        send_instr(OP_SHL, 0, AUX_RET);
        send_instr(OP_STORE, '1, AUX_RET);
        send_instr(OP_STORE, 5, AUX_RET);
        send_instr(OP_LOAD, 5, AUX_RET);
        send_instr(OP_LOAD, 70, AUX_RET);
        send_instr(OP_DUP, 0, AUX_RET);
        send_instr(OP_EQ, 0, AUX_RET);
        send_instr(OP_JMPIF, 64'h1_2345, AUX_RET);
        send_instr(OP_JMPIFNOT, 7, AUX_RET);
        send_instr(OP_JMP, 9, AUX_RET);
        send_instr(OP_RSV_A, 0, AUX_RET);
        send_instr(OP_RSV_B, 0, AUX_RET);
        send_instr(OP_TOP, '1, AUX_BAD);
        send_instr(OP_SYS, 0, AUX_BAD);
        send_instr(OP_SYS, V_MAX, AUX_HALT);
        send_instr(OP_SYS, V_MIN, AUX_RET);
        send_instr(OP_MUL, 0, AUX_RET);
        send_instr(OP_SYS, 0, AUX_PRINT);
    endtask

    task automatic test_random(input int count);
        int          r;
        logic [63:0] v;
        logic [5:0]  c;
        logic [1:0]  ax;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            v = pick_value();
            ax = AUX_RET;
            if (stk_cnt < 2 && r < 60 || r < 22) c = OP_PUSH;
            else if (r < 30) begin
                c = OP_SYS;
                ax = 2'($urandom_range(3));
            end else if (r < 36) begin
                c = ($urandom_range(1) != 0) ? OP_STORE : OP_LOAD;
                if ($urandom_range(9) != 0) v = 64'($urandom_range(DEPTH - 1));
            end else if (r < 40) c = OP_POP;
            else if (r < 45) c = ($urandom_range(1) != 0) ? OP_DUP : OP_SWAP;
            else if (r < 50) c = ($urandom_range(1) != 0) ? OP_JMPIF : OP_JMPIFNOT;
            else if (r < 53) c = 6'($urandom_range(29, 63));
            else c = 6'($urandom_range(OP_ADD, OP_NLE));
            send_instr(c, v, ax);
        end
    endtask

    task automatic test_limits();
        send_idle_pct = 31;
        sink_stall_pct = 55;
        test_random(380);
        set_limit(7'd3);
        test_random(80);
        set_limit(7'd0);
        test_random(30);
        send_idle_pct = 55;
        sink_stall_pct = 31;
        set_limit(7'd127);
        test_random(350);
        set_limit(7'd1);
        test_random(50);
        send_idle_pct = 0;
        sink_stall_pct = 0;
        set_limit(7'($urandom_range(2, 63)));
        test_random(120);
        set_limit(7'd64);
        test_random(80);
    endtask

    task automatic check_field(input string name, input logic [63:0] exp_v,
                               input logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected %h, got %h", name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk) begin
        status_word_t w;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                $error("status word with nothing expected");
                errors++;
            end else begin
                w = expected_q.pop_front();
                check_field("status", w.status, m_tdata[3:0]);
                check_field("pc_value", w.pc, m_tdata[19:4]);
                check_field("print_valid", w.pv, m_tuser[0]);
                check_field("print_value", w.pval, m_tdata[83:20]);
                check_field("top_value", w.top, m_tdata[147:84]);
                check_field("stack_depth", w.depth, m_tdata[154:148]);
                check_field("running", w.run, m_tdata[155]);
                words_checked++;
                if (w.pv) prints_seen++;
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n)
            m_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > IDLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        cfg_we <= 1'b0;
        cfg_wdata <= '0;
        s_tvalid <= 1'b0;
        s_tdata <= '0;
        s_tuser <= '0;
        m_tready <= 1'b0;
        idle_cycles = 0;
        errors = 0;
        words_sent = 0;
        words_checked = 0;
        prints_seen = 0;
        send_idle_pct = 0;
        sink_stall_pct = 0;
        stk_cnt = 0;
        slot_cnt = 0;
        pc_reg = '0;
        run_reg = 1'b1;
        limit_reg = 64;
        for (int i = 0; i < DEPTH; i++) begin
            stk_mem[i] = '0;
            slot_mem[i] = '0;
        end
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_limits();
        drain();
        $display("Ran %0d instructions, checked %0d status words (%0d prints).",
                 words_sent, words_checked, prints_seen);
        $display("Stack limits 64, 3, 0, 127, 1 and a random one; three idle patterns.");
        if (errors == 0 && expected_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

`default_nettype wire
